@@ sv/binary_max_heap_queue_defines.svh @@
// Assertion macros used by the heap queue checker.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMHQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

@@ sv/bmhq_pkg.sv @@
package bmhq_pkg;

  // opcode values
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [6:0]         fill_level;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_LAST,
    S_POP_LOAD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP
  } state_e;

endpackage

@@ sv/bmhq_ram.sv @@
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bmhq_cmp.sv @@
module bmhq_cmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               gt_o
);

  // signed strictly-greater compare, shared by sift up and sift down
  assign gt_o = (a_i > b_i);

endmodule

@@ sv/bmhq_seq.sv @@
module bmhq_seq #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  bmhq_pkg::cmd_t              cmd_i,
  output logic                        done_o,
  output bmhq_pkg::res_t              res_o,
  output logic                        ram_we_o,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr_o,
  output logic [31:0]                 ram_wdata_o,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr_o,
  input  logic [31:0]                 ram_rdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned FW = (CW > 7) ? CW : 7;

  bmhq_pkg::state_e state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               done_q, done_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic signed [31:0] cur_q, cur_d;
  logic signed [31:0] lval_q, lval_d;
  logic               lgt_q, lgt_d;
  logic signed [31:0] popped_q, popped_d;
  bmhq_pkg::res_t     res_q, res_d;

  logic               accept;
  logic               full;
  logic               empty;
  logic [AW-1:0]      parent;
  logic [IW-1:0]      left;
  logic [IW-1:0]      right;
  logic [IW-1:0]      count_x;
  logic               left_ok;
  logic               right_ok;
  logic signed [31:0] rdata;
  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_b;
  logic               gt;
  logic               fin;
  logic [1:0]         fin_status;
  logic signed [31:0] fin_pop;
  logic [FW-1:0]      cnt_ext;

  assign busy    = (state_q != bmhq_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign rdata   = $signed(ram_rdata_i);

  // heap index arithmetic
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign left     = {1'b0, pos_q, 1'b1};
  assign right    = left + IW'(1);
  assign count_x  = IW'(count_q);
  assign left_ok  = (left < count_x);
  assign right_ok = (right < count_x);
  assign cnt_ext  = FW'(count_q);

  // operand select for the shared comparator
  always_comb begin
    cmp_a = rdata;
    cmp_b = cur_q;
    case (state_q)
      bmhq_pkg::S_UP_CMP: begin
        cmp_a = cur_q;
        cmp_b = rdata;
      end
      bmhq_pkg::S_DN_CMP: begin
        cmp_b = lgt_q ? lval_q : cur_q;
      end
      default: begin
        cmp_a = rdata;
        cmp_b = cur_q;
      end
    endcase
  end

  bmhq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (gt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_i.opcode == bmhq_pkg::OP_INSERT) begin
            if (!full) state_d = bmhq_pkg::S_UP_RD;
          end else begin
            if (!empty) state_d = bmhq_pkg::S_POP_LAST;
          end
        end
      end
      bmhq_pkg::S_UP_RD: begin
        state_d = (pos_q == '0) ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_CMP;
      end
      bmhq_pkg::S_UP_CMP: begin
        state_d = gt ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_IDLE;
      end
      bmhq_pkg::S_POP_LAST: begin
        state_d = (count_q == '0) ? bmhq_pkg::S_IDLE : bmhq_pkg::S_POP_LOAD;
      end
      bmhq_pkg::S_POP_LOAD: begin
        state_d = bmhq_pkg::S_DN_RDL;
      end
      bmhq_pkg::S_DN_RDL: begin
        state_d = left_ok ? bmhq_pkg::S_DN_RDR : bmhq_pkg::S_IDLE;
      end
      bmhq_pkg::S_DN_RDR: begin
        if (right_ok) begin
          state_d = bmhq_pkg::S_DN_CMP;
        end else begin
          state_d = gt ? bmhq_pkg::S_DN_RDL : bmhq_pkg::S_IDLE;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        state_d = (gt || lgt_q) ? bmhq_pkg::S_DN_RDL : bmhq_pkg::S_IDLE;
      end
      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath controls, memory port and result
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    lval_d      = lval_q;
    lgt_d       = lgt_q;
    popped_d    = popped_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = cur_q;
    ram_raddr_o = '0;
    fin         = 1'b0;
    fin_status  = bmhq_pkg::ST_OK;
    fin_pop     = popped_q;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          popped_d = '0;
          if (cmd_i.opcode == bmhq_pkg::OP_INSERT) begin
            if (full) begin
              fin        = 1'b1;
              fin_status = bmhq_pkg::ST_FULL;
              fin_pop    = '0;
            end else begin
              cur_d   = cmd_i.item_value;
              pos_d   = count_q[AW-1:0];
              count_d = count_q + CW'(1);
            end
          end else begin
            if (empty) begin
              fin        = 1'b1;
              fin_status = bmhq_pkg::ST_EMPTY;
              fin_pop    = '0;
            end else begin
              count_d     = count_q - CW'(1);
              ram_raddr_o = '0;
            end
          end
        end
      end
      bmhq_pkg::S_UP_RD: begin
        if (pos_q == '0) begin
          ram_we_o = 1'b1;
          fin      = 1'b1;
        end else begin
          ram_raddr_o = parent;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        ram_we_o = 1'b1;
        if (gt) begin
          // parent moves down, the new value keeps climbing
          ram_wdata_o = rdata;
          pos_d       = parent;
        end else begin
          fin = 1'b1;
        end
      end
      bmhq_pkg::S_POP_LAST: begin
        // root arrives; fetch the last entry
        popped_d    = rdata;
        ram_raddr_o = count_q[AW-1:0];
        if (count_q == '0) begin
          fin     = 1'b1;
          fin_pop = rdata;
        end
      end
      bmhq_pkg::S_POP_LOAD: begin
        cur_d = rdata;
        pos_d = '0;
      end
      bmhq_pkg::S_DN_RDL: begin
        if (left_ok) begin
          ram_raddr_o = left[AW-1:0];
        end else begin
          ram_we_o = 1'b1;
          fin      = 1'b1;
        end
      end
      bmhq_pkg::S_DN_RDR: begin
        lval_d = rdata;
        lgt_d  = gt;
        if (right_ok) begin
          ram_raddr_o = right[AW-1:0];
        end else if (gt) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = rdata;
          pos_d       = left[AW-1:0];
        end else begin
          ram_we_o = 1'b1;
          fin      = 1'b1;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        ram_we_o = 1'b1;
        if (gt) begin
          ram_wdata_o = rdata;
          pos_d       = right[AW-1:0];
        end else if (lgt_q) begin
          ram_wdata_o = lval_q;
          pos_d       = left[AW-1:0];
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // result register, loaded on completion
  always_comb begin
    done_d = fin;
    res_d  = res_q;
    if (fin) begin
      res_d.status       = fin_status;
      res_d.popped_value = fin_pop;
      res_d.fill_level   = cnt_ext[6:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    lval_q   <= lval_d;
    lgt_q    <= lgt_d;
    popped_q <= popped_d;
    res_q    <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ sv/binary_max_heap_queue.sv @@
// Max-heap priority queue of signed 32-bit values, CAPACITY entries deep. A
// command is taken when start is high and busy is low; busy then stays high
// until the operation ends, and the result is shown for exactly one cycle
// with done_o high, so the receiver must take it then. An insert on a full
// heap or a remove on an empty one answers in the cycle after the transfer.
// Each heap level needs a read through the single read port of the heap RAM,
// whose read data is registered. Sift down also reads each child that exists,
// one after the other, through the same port and comparator.
// A new command may be given in the cycle that shows the previous result.
module binary_max_heap_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bmhq_pkg::cmd_t cmd_i,
  output logic           done_o,
  output bmhq_pkg::res_t res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // sequencer with the shared comparator
  bmhq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // heap storage
  bmhq_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ sv/bmhq_chk.sv @@
`include "binary_max_heap_queue_defines.svh"

module bmhq_chk #(
  parameter int unsigned CAPACITY = 64
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input bmhq_pkg::cmd_t cmd_i,
  input logic           done_o,
  input bmhq_pkg::res_t res_o
);

  localparam logic [6:0] CapFill = 7'(CAPACITY);

  // a transfer either answers at once or keeps the block busy
  `BMHQ_ASSERT_NEXT(acc_prog_a, start && !busy, busy || done_o)
  // the result cycle is always a cycle in which a new command may be taken
  `BMHQ_ASSERT_NOW(done_idle_a, done_o, !busy)
  // a full report carries the capacity as fill level
  `BMHQ_ASSERT_NOW(full_fill_a, done_o && res_o.status == bmhq_pkg::ST_FULL, res_o.fill_level == CapFill)
  // an empty report shows no entries and no popped value
  `BMHQ_ASSERT_NOW(empty_res_a, done_o && res_o.status == bmhq_pkg::ST_EMPTY, res_o.fill_level == 7'd0 && res_o.popped_value == 32'sd0)

endmodule

bind binary_max_heap_queue bmhq_chk #(
  .CAPACITY (CAPACITY)
) u_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);

@@ sim/binary_max_heap_queue_tb.sv @@
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = 64;
  localparam int RANDOM_CMDS = 530;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    cmd_t cmd;
    bit   fixed;
    res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic done_o;
  res_t res_o;

  // expectation override for directed rows, driven alongside cmd_i
  bit   row_fixed = 1'b0;
  res_t row_want = '0;

  // shadow heap used for prediction
  logic signed [31:0] shadow_heap [HEAP_DEPTH];
  int                 shadow_count = 0;

  res_t     pending_results [$];
  dir_row_t directed_rows [$];
  int       err_count = 0;
  int       cycles = 0;

  binary_max_heap_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #2 clk_i = ~clk_i;

  // apply one command to the shadow heap and return its result
  function automatic res_t heap_apply(cmd_t c);
    res_t               r;
    int                 pos;
    int                 par;
    int                 big;
    logic signed [31:0] tmp;
    r = '0;
    r.status = ST_OK;
    if (c.opcode == OP_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_heap[pos] = c.item_value;
        shadow_count++;
        // sift up while strictly greater than the parent
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (!(shadow_heap[pos] > shadow_heap[par])) break;
          tmp = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[par];
          shadow_heap[par] = tmp;
          pos = par;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_value = shadow_heap[0];
        shadow_heap[0] = shadow_heap[shadow_count - 1];
        shadow_count--;
        // sift down toward the larger child; ties stay with node, then left
        pos = 0;
        while (pos < shadow_count) begin
          big = pos;
          if (2 * pos + 1 < shadow_count && shadow_heap[2 * pos + 1] > shadow_heap[big])
            big = 2 * pos + 1;
          if (2 * pos + 2 < shadow_count && shadow_heap[2 * pos + 2] > shadow_heap[big])
            big = 2 * pos + 2;
          if (big == pos) break;
          tmp = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[big];
          shadow_heap[big] = tmp;
          pos = big;
        end
      end
    end
    r.fill_level = 7'(shadow_count);
    return r;
  endfunction

  // result check and transfer capture, both on the rising edge
  always @(posedge clk_i) begin
    res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("binary_max_heap_queue_tb: errors");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d value %0d fill %0d", $time,
                   res_o.status, res_o.popped_value, res_o.fill_level);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, res_o.status);
            err_count++;
          end
          if (res_o.popped_value !== want.popped_value) begin
            $display("%0t: popped_value expected %0d got %0d", $time,
                     want.popped_value, res_o.popped_value);
            err_count++;
          end
          if (res_o.fill_level !== want.fill_level) begin
            $display("%0t: fill_level expected %0d got %0d", $time,
                     want.fill_level, res_o.fill_level);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        want = heap_apply(cmd_i);
        if (row_fixed) want = row_want;
        pending_results.push_back(want);
      end
    end
  end

  function automatic void add_row(logic op, logic signed [31:0] val, bit fixed,
                                  logic [1:0] st, logic signed [31:0] pv, logic [6:0] fl);
    dir_row_t row;
    row.cmd.opcode = op;
    row.cmd.item_value = (op == OP_REMOVE) ? 32'($urandom) : val;
    row.fixed = fixed;
    row.want.status = st;
    row.want.popped_value = pv;
    row.want.fill_level = fl;
    directed_rows.push_back(row);
  endfunction

  // mostly wide random values, some small ones to force ties, some extremes
  function automatic logic signed [31:0] draw_value();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) return 32'($urandom_range(0, 7)) - 32'sd4;
    if (pick == 2) return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
    return 32'($urandom);
  endfunction

  // one command transfer, after an optional idle gap
  task automatic issue(cmd_t c, bit fixed, res_t want, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    row_fixed <= fixed;
    row_want <= want;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    cmd_t c;
    int   sent;
    int   phase;
    int   phase_len;
    int   insert_pct;
    bit   no_gap;
    sent = 0;
    phase = 0;

    // directed rows: empty, extremes, equal values, drain to empty again
    add_row(OP_REMOVE, 0, 1, ST_EMPTY, 0, 0);
    add_row(OP_INSERT, 32'sh7FFFFFFF, 1, ST_OK, 0, 1);
    add_row(OP_INSERT, 32'sh80000000, 1, ST_OK, 0, 2);
    add_row(OP_INSERT, 32'sh00000000, 0, ST_OK, 0, 0);
    add_row(OP_INSERT, -32'sd1, 0, ST_OK, 0, 0);
    add_row(OP_INSERT, 32'sh7FFFFFFF, 0, ST_OK, 0, 0);
    add_row(OP_INSERT, 32'sh80000000, 0, ST_OK, 0, 0);
    add_row(OP_INSERT, 32'sd5, 0, ST_OK, 0, 0);
    add_row(OP_INSERT, 32'sd5, 0, ST_OK, 0, 0);
    add_row(OP_REMOVE, 0, 1, ST_OK, 32'sh7FFFFFFF, 7);
    add_row(OP_REMOVE, 0, 1, ST_OK, 32'sh7FFFFFFF, 6);
    add_row(OP_REMOVE, 0, 0, ST_OK, 0, 0);
    add_row(OP_REMOVE, 0, 0, ST_OK, 0, 0);
    add_row(OP_REMOVE, 0, 0, ST_OK, 0, 0);
    add_row(OP_REMOVE, 0, 0, ST_OK, 0, 0);
    add_row(OP_REMOVE, 0, 0, ST_OK, 0, 0);
    add_row(OP_REMOVE, 0, 1, ST_OK, 32'sh80000000, 0);
    add_row(OP_REMOVE, 0, 1, ST_EMPTY, 0, 0);
    add_row(OP_INSERT, 32'sd1, 1, ST_OK, 0, 1);
    add_row(OP_REMOVE, 0, 1, ST_OK, 32'sd1, 0);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want,
            $urandom_range(0, 2) == 0);

    // random phases in turn: insert-heavy toward full, remove-heavy toward empty, then mixed traffic
    while (sent < RANDOM_CMDS) begin
      case (phase % 3)
        0: begin phase_len = 90; insert_pct = 85; end
        1: begin phase_len = 90; insert_pct = 15; end
        default: begin phase_len = 40; insert_pct = 50; end
      endcase
      no_gap = ($urandom_range(0, 2) == 0);
      repeat (phase_len) begin
        c.opcode = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        c.item_value = draw_value();
        issue(c, 1'b0, '0, no_gap);
        sent++;
      end
      phase++;
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("binary_max_heap_queue_tb: clean");
    else
      $display("binary_max_heap_queue_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_cmp.sv
sv/bmhq_seq.sv
sv/binary_max_heap_queue.sv
sv/bmhq_chk.sv
sim/binary_max_heap_queue_tb.sv
